### src/sha_pkg.sv
// SHA-256 package: round constants, initial hash values, round functions.
// No dependencies.
package sha_pkg;

    localparam logic [0:0] OP_ABSORB = 1'b0;
    localparam logic [0:0] OP_FINISH = 1'b1;

    typedef logic [31:0] t_word;

    localparam t_word K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam t_word H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word ssig0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word ssig1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word bsig0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

### src/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher top level.
// Depends on sha_pkg.
//
// Bytes are packed into 32-bit words and stored in a 16-word message
// memory that doubles as the schedule window. An absorb transfer is taken
// while the block is idle; the one completing a 64-byte block then holds
// the input for the compression, in which each round reads the window and
// then does a read-modify-write, and a final step folds the working
// variables into the chain. A finish transfer writes the padding words one
// per cycle, runs one or two compressions, then emits eight digest words
// on the master side; the output stage is a register, so each word waits
// for tready. Reads of the window memory are registered. Message length
// counts absorbed bytes only, in bits modulo 2^64.
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast    // last_word
);
    import sha_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;   // writing padding words
    localparam logic [2:0] S_RD   = 3'd2;   // round: issue window reads
    localparam logic [2:0] S_RMW  = 3'd3;   // round: compute, write back
    localparam logic [2:0] S_FOLD = 3'd4;   // add working vars into chain
    localparam logic [2:0] S_OUT  = 3'd5;

    t_word r_mem [16];
    t_word r_rd0, r_rd1, r_rd2, r_rd3;

    logic [2:0]  r_state;
    t_word       r_h [8];
    t_word       r_v [8];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [23:0] r_part;     // bytes of the word being assembled
    logic [5:0]  r_rnd;
    logic [3:0]  r_padw;     // padding word index
    logic        r_fin;      // compression belongs to a finish
    logic        r_second;   // padding needs an extra block
    logic [2:0]  r_oidx;
    logic        r_ovalid;

    // window addresses for the current round
    logic [3:0] a_t, a_2, a_7, a_15;
    assign a_t  = r_rnd[3:0];
    assign a_2  = r_rnd[3:0] - 4'd2;
    assign a_7  = r_rnd[3:0] - 4'd7;
    assign a_15 = r_rnd[3:0] - 4'd15;

    always_ff @(posedge i_clk) begin
        r_rd0 <= r_mem[a_t];
        r_rd1 <= r_mem[a_2];
        r_rd2 <= r_mem[a_7];
        r_rd3 <= r_mem[a_15];
    end

    logic accept;
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    // padding word content for word slot r_padw
    logic [3:0]  fillw;
    logic [1:0]  fillb;
    t_word       padword;
    assign fillw = r_fill[5:2];
    assign fillb = r_fill[1:0];
    always_comb begin
        padword = '0;
        if (r_second && r_fin) begin
            padword = '0;
            if (r_padw == 4'd14) padword = r_bits[63:32];
            if (r_padw == 4'd15) padword = r_bits[31:0];
        end else if (r_padw == fillw) begin
            case (fillb)
                2'd0: padword = {PAD_BYTE, 24'd0};
                2'd1: padword = {r_part[7:0], PAD_BYTE, 16'd0};
                2'd2: padword = {r_part[15:0], PAD_BYTE, 8'd0};
                default: padword = {r_part[23:0], PAD_BYTE};
            endcase
        end else if (r_padw == 4'd14 && r_fill < 6'd56) begin
            padword = r_bits[63:32];
        end else if (r_padw == 4'd15 && r_fill < 6'd56) begin
            padword = r_bits[31:0];
        end
    end

    // round datapath
    t_word w, t1, t2;
    always_comb begin
        if (r_rnd < 6'd16) w = r_rd0;
        else w = ssig1(r_rd1) + r_rd2 + ssig0(r_rd3) + r_rd0;
        t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + K_TAB[r_rnd] + w;
        t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept && s_axis_tuser == OP_ABSORB && fillb == 2'd3)
            r_mem[fillw] <= {r_part, s_axis_tdata[7:0]};
        else if (r_state == S_PAD)
            r_mem[r_padw] <= padword;
        else if (r_state == S_RMW && r_rnd >= 6'd16)
            r_mem[a_t] <= w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_bits   <= '0;
            r_fin    <= 1'b0;
            r_second <= 1'b0;
            r_ovalid <= 1'b0;
            r_oidx   <= '0;
            r_rnd    <= '0;
            r_padw   <= '0;
            for (int k = 0; k < 8; k++) r_h[k] <= H_INIT[k];
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (s_axis_tuser == OP_ABSORB) begin
                            r_part <= {r_part[15:0], s_axis_tdata[7:0]};
                            r_fill <= r_fill + 6'd1;
                            r_bits <= r_bits + 64'd8;
                            if (r_fill == 6'd63) begin
                                r_fin <= 1'b0;
                                r_rnd <= '0;
                                for (int k = 0; k < 8; k++) r_v[k] <= r_h[k];
                                r_state <= S_RD;
                            end
                        end else begin
                            r_fin    <= 1'b1;
                            r_second <= 1'b0;
                            r_padw   <= fillw;
                            r_state  <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_padw <= r_padw + 4'd1;
                    if (r_padw == 4'd15) begin
                        r_rnd <= '0;
                        for (int k = 0; k < 8; k++) r_v[k] <= r_h[k];
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_RMW;
                S_RMW: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd  <= r_rnd + 6'd1;
                    r_state <= (r_rnd == 6'd63) ? S_FOLD : S_RD;
                end
                S_FOLD: begin
                    for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (!r_second && r_fill >= 6'd56) begin
                        // length did not fit: all-zero block with length
                        r_second <= 1'b1;
                        r_padw   <= '0;
                        r_state  <= S_PAD;
                    end else begin
                        r_oidx   <= '0;
                        r_ovalid <= 1'b1;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_ovalid <= 1'b0;
                            r_fill   <= '0;
                            r_bits   <= '0;
                            for (int k = 0; k < 8; k++) r_h[k] <= H_INIT[k];
                            r_state  <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_oidx, r_h[r_oidx]};
    assign m_axis_tlast  = (r_oidx == 3'd7);

endmodule
